// File: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, register map, reset values and constant tables of the
// envelope soft clipper.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int CHANNELS_DEF = 2;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_THR   = 3'd0;
  localparam logic [2:0] REG_HL    = 3'd1;
  localparam logic [2:0] REG_SLOPE = 3'd2;
  localparam logic [2:0] REG_LIN   = 3'd3;
  localparam logic [2:0] REG_ATK   = 3'd4;
  localparam logic [2:0] REG_DEC   = 3'd5;
  localparam logic [2:0] REG_MTR   = 3'd6;

  // Reset values of the registers
  localparam logic [22:0] THR_RST   = 23'd629146;
  localparam logic [22:0] HL_RST    = 23'd1048576;
  localparam logic [16:0] SLOPE_RST = 17'd32768;
  localparam logic        LIN_RST   = 1'b0;
  localparam logic [15:0] ATK_RST   = 16'd64857;
  localparam logic [15:0] DEC_RST   = 16'd65263;
  localparam logic [23:0] MTR_RST   = 24'd16776866;

  // Classified input item, as it travels through the queue
  typedef struct packed {
    logic        neg;   // sample sign
    logic [23:0] imag;  // sample magnitude, up to 2^23
    logic        ch;    // channel, already clamped
    logic        fend;  // last sample of a frame
  } item_t;

  // Configuration register bundle
  typedef struct packed {
    logic [22:0] thr;
    logic [22:0] hl;
    logic [16:0] slope;
    logic        lin;
    logic [15:0] ca;
    logic [15:0] cd;
    logic [23:0] cm;
  } cfg_t;

  // Sequencer states of the back end
  typedef enum logic [4:0] {
    S_IDLE, S_ATK0, S_ATK1, S_ATKW, S_DEC0, S_DEC1, S_DECW, S_KNEE,
    S_LIN0, S_LIN1, S_LIN2, S_DIV, S_DIVQ,
    S_LSQ, S_EXP0, S_EXP1, S_EXPK, S_GAIN, S_GAINW,
    S_FIN, S_MTR, S_OUT
  } state_t;

  typedef logic [15:0][30:0] root_tbl_t;

  // Floor integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry k holds 2^-(2^(k-16)) in Q.30, by repeated square roots of 0.5
  function automatic root_tbl_t build_roots();
    root_tbl_t   t;
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      r = isqrt64(r << 30);
      t[k] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

// File: hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Input side: takes items, splits sign and magnitude, clamps the channel
// and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module esc_front
  import esc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  input  logic        in_tuser,   // [0] channel_index
  input  logic        in_tlast,   // frame_end
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic [23:0] smp;

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign smp       = in_tdata;

  // Classify: sign, magnitude, clamped channel
  always_comb begin
    q_item.neg  = smp[23];
    q_item.imag = smp[23] ? (~smp + 24'd1) : smp;
    q_item.ch   = (CHANNELS > 1) ? in_tuser : 1'b0;
    q_item.fend = in_tlast;
  end

endmodule

// File: hdl/esc_queue.sv
// ----------------------------------------------------------------------------
// esc_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module esc_queue
  import esc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t       mem_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rptr_r];

  // Advance pointers and count
  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Back end: envelope update, linear or power-law knee, hard limit, frame
// meter and output register, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
module esc_back
  import esc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [23:0] sample_out, [47:24] clip_ratio, zero pad
  output logic [1:0]  out_tuser   // [0] sample_clipped, [1] ratio_valid
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t      state_r, state_nxt;
  item_t       item_r, item_nxt;
  logic [22:0] aenv_r [CHANNELS];
  logic [22:0] aenv_nxt [CHANNELS];
  logic [22:0] denv_r [CHANNELS];
  logic [22:0] denv_nxt [CHANNELS];
  logic [22:0] a_r, a_nxt;
  logic [22:0] d_r, d_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] m_r, m_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [20:0] ld_r, ld_nxt;
  logic        lsel_r, lsel_nxt;
  logic [20:0] e_r, e_nxt;
  logic [30:0] g_r, g_nxt;
  logic [14:0] nhi_r, nhi_nxt;
  logic [24:0] omag_r, omag_nxt;
  logic        clip_r, clip_nxt;
  logic        ff_r, ff_nxt;
  logic [23:0] meter_r, meter_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [23:0] osmp_r, osmp_nxt;
  logic [23:0] omtr_r, omtr_nxt;
  logic        oclip_r, oclip_nxt;
  logic        orv_r, orv_nxt;

  logic [31:0] mx, my;
  logic [63:0] prod;
  logic [CH_W-1:0] ch_idx;
  logic [22:0] mag;
  logic [16:0] slope_c;
  logic [22:0] thr_t;
  logic [35:0] nrm_d, nrm_t;
  logic [31:0] mm;
  logic [15:0] bits_new;
  logic [20:0] lg_new;
  logic [30:0] gp;
  logic [30:0] g_sh;
  logic [38:0] den;
  logic [40:0] diff;
  logic [39:0] tdiv;
  logic [22:0] lm;
  logic [24:0] mtr_new;

  // Leading one and left alignment of a 23 bit value into Q.30
  function automatic logic [35:0] norm23(input logic [22:0] x);
    logic [4:0]  p;
    logic [30:0] m;
    p = 5'd0;
    for (int i = 1; i < 23; i++) begin
      if (x[i]) p = 5'(i);
    end
    m = {8'd0, x} << (5'd30 - p);
    return {p, m};
  endfunction

  // Shared multiplier
  assign prod = mx * my;

  assign ch_idx   = CH_W'(item_r.ch);
  assign mag      = item_r.imag[23] ? 23'h7FFFFF : item_r.imag[22:0];
  assign slope_c  = cfg.slope[16] ? 17'h10000 : cfg.slope;
  assign thr_t    = (cfg.thr == 23'd0) ? 23'd1 : cfg.thr;
  assign nrm_d    = norm23(d_r);
  assign nrm_t    = norm23(thr_t);
  assign mm       = prod[61:30];
  assign bits_new = {bits_r[14:0], mm[31]};
  assign lg_new   = {p_r, bits_new};
  assign gp       = prod[60:30] + 31'(prod[29]);
  assign g_sh     = (e_r[20:16] == 5'd31) ? 31'd0 : (g_r >> e_r[20:16]);
  assign den      = {d_r, 16'd0};
  assign tdiv     = {acc_r[63:25], acc_r[24]};
  assign diff     = {1'b0, tdiv} - {2'b0, den};
  assign lm       = (omag_r > {2'b0, cfg.hl}) ? cfg.hl : omag_r[22:0];
  assign mtr_new  = acc_r[48:24];

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, 1'b0, omtr_r, osmp_r};
  assign out_tuser  = {orv_r, oclip_r};

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    aenv_nxt  = aenv_r;
    denv_nxt  = denv_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    m_nxt     = m_r;
    bits_nxt  = bits_r;
    p_nxt     = p_r;
    ld_nxt    = ld_r;
    lsel_nxt  = lsel_r;
    e_nxt     = e_r;
    g_nxt     = g_r;
    nhi_nxt   = nhi_r;
    omag_nxt  = omag_r;
    clip_nxt  = clip_r;
    ff_nxt    = ff_r;
    meter_nxt = meter_r;
    osmp_nxt  = osmp_r;
    omtr_nxt  = omtr_r;
    oclip_nxt = oclip_r;
    orv_nxt   = orv_r;
    ovalid_nxt = (ovalid_r && out_tready) ? 1'b0 : ovalid_r;
    mx = 32'd0;
    my = 32'd0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          state_nxt = S_ATK0;
        end
      end
      // Attack lowpass of the magnitude
      S_ATK0: begin
        mx = 32'(cfg.ca);
        my = 32'(aenv_r[ch_idx]);
        acc_nxt = prod + 64'd32768;
        state_nxt = S_ATK1;
      end
      S_ATK1: begin
        mx = 32'(17'h10000 - {1'b0, cfg.ca});
        my = 32'(mag);
        acc_nxt = acc_r + prod;
        state_nxt = S_ATKW;
      end
      S_ATKW: begin
        a_nxt = acc_r[38:16];
        aenv_nxt[ch_idx] = acc_r[38:16];
        if (acc_r[38:16] >= denv_r[ch_idx]) begin
          d_nxt = acc_r[38:16];
          denv_nxt[ch_idx] = acc_r[38:16];
          state_nxt = S_KNEE;
        end else begin
          d_nxt = denv_r[ch_idx];
          state_nxt = S_DEC0;
        end
      end
      // Decay of the max tracker
      S_DEC0: begin
        mx = 32'(cfg.cd);
        my = 32'(d_r);
        acc_nxt = prod + 64'd32768;
        state_nxt = S_DEC1;
      end
      S_DEC1: begin
        mx = 32'(17'h10000 - {1'b0, cfg.cd});
        my = 32'(a_r);
        acc_nxt = acc_r + prod;
        state_nxt = S_DECW;
      end
      S_DECW: begin
        d_nxt = acc_r[38:16];
        denv_nxt[ch_idx] = acc_r[38:16];
        state_nxt = S_KNEE;
      end
      // Pick the knee
      S_KNEE: begin
        clip_nxt = (d_r > cfg.thr);
        if (!(d_r > cfg.thr)) begin
          omag_nxt  = {1'b0, item_r.imag};
          state_nxt = S_FIN;
        end else if (cfg.lin) begin
          state_nxt = S_LIN0;
        end else begin
          lsel_nxt  = 1'b0;
          p_nxt     = nrm_d[35:31];
          m_nxt     = nrm_d[30:0];
          bits_nxt  = 16'd0;
          cnt_nxt   = 5'd0;
          state_nxt = S_LSQ;
        end
      end
      // Linear knee: numerator, then magnitude times numerator
      S_LIN0: begin
        mx = 32'(d_r - cfg.thr);
        my = 32'(slope_c);
        acc_nxt = prod + {25'd0, cfg.thr, 16'd0};
        state_nxt = S_LIN1;
      end
      S_LIN1: begin
        mx = 32'(item_r.imag);
        my = 32'(acc_r[23:0]);
        nhi_nxt = acc_r[38:24];
        acc_nxt = prod + {26'd0, d_r, 15'd0};
        state_nxt = S_LIN2;
      end
      S_LIN2: begin
        mx = 32'(item_r.imag);
        my = 32'(nhi_r);
        acc_nxt = acc_r + (prod << 24);
        cnt_nxt = 5'd0;
        state_nxt = S_DIV;
      end
      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        if (!diff[40]) begin
          acc_nxt = {diff[38:0], acc_r[23:0], 1'b1};
        end else begin
          acc_nxt = {tdiv[38:0], acc_r[23:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd24) state_nxt = S_DIVQ;
      end
      S_DIVQ: begin
        omag_nxt  = acc_r[24:0];
        state_nxt = S_FIN;
      end
      // Log2 by repeated squaring, first of the envelope, then of the threshold
      S_LSQ: begin
        mx = 32'(m_r);
        my = 32'(m_r);
        bits_nxt = bits_new;
        m_nxt = mm[31] ? mm[31:1] : mm[30:0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          if (!lsel_r) begin
            ld_nxt   = lg_new;
            lsel_nxt = 1'b1;
            p_nxt    = nrm_t[35:31];
            m_nxt    = nrm_t[30:0];
            bits_nxt = 16'd0;
            cnt_nxt  = 5'd0;
          end else begin
            e_nxt     = ld_r - lg_new;
            state_nxt = S_EXP0;
          end
        end
      end
      // Exponent of the power-law gain
      S_EXP0: begin
        mx = 32'(17'h10000 - slope_c);
        my = 32'(e_r);
        acc_nxt = prod + 64'd32768;
        state_nxt = S_EXP1;
      end
      S_EXP1: begin
        e_nxt = acc_r[36:16];
        g_nxt = 31'h40000000;
        cnt_nxt = 5'd15;
        state_nxt = S_EXPK;
      end
      // Fractional power of two, one exponent bit per cycle
      S_EXPK: begin
        mx = 32'(g_r);
        my = 32'(ROOT_TBL[cnt_r[3:0]]);
        if (e_r[cnt_r[3:0]]) g_nxt = gp;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = S_GAIN;
      end
      S_GAIN: begin
        mx = 32'(item_r.imag);
        my = 32'(g_sh);
        acc_nxt = prod + 64'h20000000;
        state_nxt = S_GAINW;
      end
      S_GAINW: begin
        omag_nxt  = acc_r[54:30];
        state_nxt = S_FIN;
      end
      // Collect the frame flag, update the meter at frame end
      S_FIN: begin
        ff_nxt = ff_r | clip_r;
        if (item_r.fend) begin
          mx = 32'(cfg.cm);
          my = 32'(meter_r);
          acc_nxt = prod + 64'h800000 +
                    ((ff_r | clip_r) ? {15'd0, 25'h1000000 - {1'b0, cfg.cm}, 24'd0}
                                     : 64'd0);
          state_nxt = S_MTR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MTR: begin
        meter_nxt = mtr_new[24] ? 24'hFFFFFF : mtr_new[23:0];
        ff_nxt    = 1'b0;
        state_nxt = S_OUT;
      end
      // Hard limit and hand the item to the output register
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          osmp_nxt   = item_r.neg ? (24'd0 - {1'b0, lm}) : {1'b0, lm};
          omtr_nxt   = meter_r;
          oclip_nxt  = clip_r;
          orv_nxt    = item_r.fend;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Channel state, meter and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        aenv_r[c] <= 23'd0;
        denv_r[c] <= 23'd0;
      end
      meter_r  <= 24'd0;
      ff_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      aenv_r   <= aenv_nxt;
      denv_r   <= denv_nxt;
      meter_r  <= meter_nxt;
      ff_r     <= ff_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    a_r    <= a_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    m_r    <= m_nxt;
    bits_r <= bits_nxt;
    p_r    <= p_nxt;
    ld_r   <= ld_nxt;
    lsel_r <= lsel_nxt;
    e_r    <= e_nxt;
    g_r    <= g_nxt;
    nhi_r  <= nhi_nxt;
    omag_r <= omag_nxt;
    clip_r <= clip_nxt;
    osmp_r <= osmp_nxt;
    omtr_r <= omtr_nxt;
    oclip_r <= oclip_nxt;
    orv_r  <= orv_nxt;
  end

endmodule

// File: hdl/envelope_soft_clipper.sv
// Knees: the linear knee runs a restoring divider; the power-law knee runs
//   two 16-step log squarings and a 16-step gain build on one multiplier.
// Flow: the back-end sequencer takes a new item only when done with the last;
//   a two-entry queue takes new items while the back end works.
// Reset: synchronous active-low; clears envelopes, meter, frame flag, queue,
//   sequencer and output valid, and loads register reset values.
// ----------------------------------------------------------------------------
// envelope_soft_clipper
// Per-channel envelope soft clipper with hard limit and clipped-frame meter.
// ----------------------------------------------------------------------------
module envelope_soft_clipper
  import esc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  input  logic        in_tuser,   // [0] channel_index
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [23:0] sample_out, [47:24] clip_ratio, zero pad
  output logic [1:0]  out_tuser,  // [0] sample_clipped, [1] ratio_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full, q_push, q_pop, q_valid;
  item_t f_item, q_head;

  // Register file writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_THR:   cfg_nxt.thr   = cfg_wdata[22:0];
        REG_HL:    cfg_nxt.hl    = cfg_wdata[22:0];
        REG_SLOPE: cfg_nxt.slope = cfg_wdata[16:0];
        REG_LIN:   cfg_nxt.lin   = cfg_wdata[0];
        REG_ATK:   cfg_nxt.ca    = cfg_wdata[15:0];
        REG_DEC:   cfg_nxt.cd    = cfg_wdata[15:0];
        REG_MTR:   cfg_nxt.cm    = cfg_wdata[23:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr   <= THR_RST;
      cfg_r.hl    <= HL_RST;
      cfg_r.slope <= SLOPE_RST;
      cfg_r.lin   <= LIN_RST;
      cfg_r.ca    <= ATK_RST;
      cfg_r.cd    <= DEC_RST;
      cfg_r.cm    <= MTR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  esc_front #(.CHANNELS(CHANNELS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item)
  );

  esc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  esc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/envelope_soft_clipper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_soft_clipper_tb
// Drives audio items with random channel, frame marks and stalls through the
// soft clipper, predicts envelope, knee, limit and meter in a scoreboard and
// checks each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module envelope_soft_clipper_tb;
  import esc_pkg::*;

  typedef struct {
    logic [23:0] smp;
    logic        clp;
    logic [24:0] ratio;
    logic        rvalid;
  } clip_result_t;

  int unsigned err_count = 0;

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  class clip_scoreboard;
    logic [63:0]  thr, hl, slope, lin, ca, cd, cm;
    logic [63:0]  atk_env[2];
    logic [63:0]  dec_env[2];
    logic [63:0]  meter;
    logic         frame_flag;
    clip_result_t pending[$];

    function new();
      thr = THR_RST; hl = HL_RST; slope = SLOPE_RST; lin = LIN_RST;
      ca = ATK_RST; cd = DEC_RST; cm = MTR_RST;
      atk_env[0] = 0; atk_env[1] = 0; dec_env[0] = 0; dec_env[1] = 0;
      meter = 0; frame_flag = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] v);
      case (idx)
        REG_THR:   thr = v[22:0];
        REG_HL:    hl = v[22:0];
        REG_SLOPE: slope = v[16:0];
        REG_LIN:   lin = v[0];
        REG_ATK:   ca = v[15:0];
        REG_DEC:   cd = v[15:0];
        REG_MTR:   cm = v[23:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] x_in);
      logic [63:0] x, r, b;
      x = x_in; r = 0; b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b); r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] log2_fix(logic [63:0] x);
      int unsigned p;
      logic [63:0] m, bits;
      p = 0; bits = 0;
      while (p < 23 && (x >> (p + 1)) != 0) p++;
      m = x << (30 - p);
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        bits = bits << 1;
        if (m >= (64'd1 << 31)) begin
          bits[0] = 1'b1; m = m >> 1;
        end
      end
      return (64'(p) << 16) | bits;
    endfunction

    function logic [63:0] exp2_frac(logic [63:0] f);
      logic [63:0] g, r;
      g = 64'd1 << 30; r = 64'd1 << 29;
      for (int k = 15; k >= 0; k--) begin
        r = floor_sqrt(r << 30);
        if (f[k]) g = (g * r + (64'd1 << 29)) >> 30;
      end
      return g;
    endfunction

    // Predict the result of one accepted input item
    function void note_input(logic [23:0] smp, logic ch, logic fend);
      logic [63:0] in_mag, mag, a, d, sl, t, omag, num, den, lg, e, ip, g, m;
      longint res, lim;
      logic clipped, neg;
      clip_result_t r;
      neg = smp[23];
      in_mag = neg ? 64'(-$signed({{40{1'b1}}, smp})) : 64'(smp);
      mag = in_mag > 8388607 ? 8388607 : in_mag;
      a = (ca * atk_env[ch] + (65536 - ca) * mag + 32768) >> 16;
      atk_env[ch] = a;
      d = dec_env[ch];
      if (a >= d) d = a;
      else d = (cd * d + (65536 - cd) * a + 32768) >> 16;
      dec_env[ch] = d;
      sl = slope > 65536 ? 65536 : slope;
      omag = in_mag; clipped = 0;
      if (d > thr) begin
        clipped = 1;
        if (lin) begin
          num = (d - thr) * sl + thr * 65536;
          den = d * 65536;
          omag = (in_mag * num + den / 2) / den;
        end else begin
          t = thr == 0 ? 1 : thr;
          lg = log2_fix(d) - log2_fix(t);
          e = ((65536 - sl) * lg + 32768) >> 16;
          ip = e >> 16;
          g = ip >= 31 ? 0 : (exp2_frac(e & 16'hFFFF) >> ip);
          omag = (in_mag * g + (64'd1 << 29)) >> 30;
        end
      end
      res = neg ? -longint'(omag) : longint'(omag);
      lim = longint'(hl);
      if (res > lim) res = lim;
      if (res < -lim) res = -lim;
      frame_flag = frame_flag | clipped;
      r.rvalid = 0;
      if (fend) begin
        m = (cm * meter + ((64'd1 << 24) - cm) * (frame_flag ? (64'd1 << 24) : 0)
             + (64'd1 << 23)) >> 24;
        meter = m > 16777215 ? 16777215 : m;
        frame_flag = 0;
        r.rvalid = 1;
      end
      r.smp = res[23:0];
      r.clp = clipped;
      r.ratio = meter[24:0];
      pending.push_back(r);
    endfunction

    // Compare one result item with the oldest prediction
    task check_result(logic [55:0] data, logic [1:0] user);
      clip_result_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item data=%h", data));
        return;
      end
      r = pending.pop_front();
      if (data[23:0] !== r.smp)
        report($sformatf("sample_out %h, want %h", data[23:0], r.smp));
      if (user[0] !== r.clp)
        report($sformatf("sample_clipped %b, want %b", user[0], r.clp));
      if (data[48:24] !== r.ratio)
        report($sformatf("clip_ratio %h, want %h", data[48:24], r.ratio));
      if (user[1] !== r.rvalid)
        report($sformatf("ratio_valid %b, want %b", user[1], r.rvalid));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = 0;
  logic        in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = 0;
  logic [23:0] cfg_wdata = 0;
  bit          calm = 0;

  clip_scoreboard sb = new();

  envelope_soft_clipper dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(40_000_000);
    $display("[envelope_soft_clipper] ERROR");
    $finish;
  end

  // Accept result items with random stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Send one input item, holding it until accepted
  task automatic send_item(input logic [23:0] smp, input logic ch, input logic fend);
    while (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= smp; in_tuser <= ch; in_tlast <= fend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(smp, ch, fend);
  endtask

  // Drop valid and wait until every result is back plus latency
  task automatic drain();
    int n;
    in_tvalid <= 0;
    @(posedge clk);
    n = 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk); n++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(int sel);
    case (sel)
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'(($urandom_range(2) == 0) ? $urandom : $urandom_range(2097152));
      default: return 24'($signed(-$urandom_range(2097152)));
    endcase
  endfunction

  task automatic random_frames(input int n_items);
    int i;
    logic ch;
    i = 0; ch = 0;
    while (i < n_items) begin
      // mostly stereo frames, some odd orderings
      if ($urandom_range(9) < 8) begin
        send_item(rand_sample($urandom_range(3)), 0, 0);
        send_item(rand_sample($urandom_range(3)), 1, 1);
        i += 2;
      end else begin
        send_item(rand_sample($urandom_range(3)), 1'($urandom), 1'($urandom));
        i++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes under reset settings
    calm = 1;
    send_item(24'h000000, 0, 0);
    send_item(24'h7FFFFF, 1, 1);
    send_item(24'h800000, 0, 0);
    send_item(24'h800001, 1, 1);
    send_item(24'h000001, 0, 1);
    send_item(24'hFFFFFF, 1, 0);
    repeat (4) send_item(24'h7FFFFF, 0, 1);
    drain();

    // Linear knee, slope above one, zero hard limit
    write_reg(REG_LIN, 24'd1);
    write_reg(REG_SLOPE, 24'h1FFFF);
    write_reg(REG_HL, 24'd0);
    write_reg(REG_ATK, 24'd0);
    send_item(24'h7FFFFF, 0, 1);
    send_item(24'h800000, 1, 1);
    drain();

    // Power-law knee with zero threshold, zero slope, zero then max meter coefficient
    write_reg(REG_LIN, 24'd0);
    write_reg(REG_THR, 24'd0);
    write_reg(REG_SLOPE, 24'd0);
    write_reg(REG_HL, 24'h7FFFFF);
    write_reg(REG_DEC, 24'hFFFF);
    write_reg(REG_MTR, 24'd0);
    send_item(24'h7FFFFF, 0, 1);
    send_item(24'h000001, 1, 1);
    send_item(24'h800000, 0, 1);
    drain();
    write_reg(REG_MTR, 24'hFFFFFF);
    write_reg(REG_THR, 24'h7FFFFF);
    write_reg(REG_DEC, 24'd0);
    write_reg(REG_ATK, 24'hFFFF);
    send_item(24'h7FFFFF, 1, 1);
    send_item(24'h400000, 0, 0);
    drain();
    calm = 0;

    // Random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_THR, 24'($urandom_range(1048576)));
      write_reg(REG_HL, 24'(ph == 3 ? 1 : $urandom_range(8388607, 1)));
      write_reg(REG_SLOPE, 24'($urandom_range(70000)));
      write_reg(REG_LIN, 24'(ph[0]));
      write_reg(REG_ATK, 24'(ph == 5 ? 0 : $urandom_range(65535)));
      write_reg(REG_DEC, 24'(ph == 6 ? 65535 : $urandom_range(65535)));
      write_reg(REG_MTR, 24'($urandom_range(16777215, 15000000)));
      calm = (ph == 4);
      random_frames(80);
      drain();
    end

    if (err_count == 0) begin
      $display("[envelope_soft_clipper] OK");
    end else begin
      $display("[envelope_soft_clipper] ERROR");
    end
    $finish;
  end

endmodule
